// ===== rtl/tmd_pkg.sv =====
// ----------------------------------------------------------------------------
// tmd_pkg
// shared widths, types and constants of the trimmed mean decimator
// ----------------------------------------------------------------------------
package tmd_pkg;

    localparam int CHANNEL_W = 3;
    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 17;
    localparam int COUNT_W   = 5;
    localparam int CUT_W     = SAMPLE_W + 1;
    localparam int MEAN_SHIFT = 4;

    typedef logic [CHANNEL_W-1:0] channel_t;
    typedef logic [SAMPLE_W-1:0]  sample_t;
    typedef logic [SUM_W-1:0]     sum_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [CUT_W-1:0]     cut_t;

    localparam count_t  WINDOW_LEN = count_t'(18);
    localparam sample_t SAMPLE_TOP = '1;

endpackage

// ===== rtl/tmd_in_if.sv =====
// ----------------------------------------------------------------------------
// tmd_in_if
// sample channel: one tagged converter sample per item
// ----------------------------------------------------------------------------
interface tmd_in_if import tmd_pkg::*;;

    logic     valid;
    logic     ready;
    channel_t channel;
    sample_t  sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);

endinterface

// ===== rtl/tmd_out_if.sv =====
// ----------------------------------------------------------------------------
// tmd_out_if
// result channel: one filtered value per completed window
// ----------------------------------------------------------------------------
interface tmd_out_if import tmd_pkg::*;;

    logic     valid;
    logic     ready;
    channel_t out_channel;
    sample_t  filtered;

    modport source (output valid, output out_channel, output filtered, input ready);
    modport sink   (input valid, input out_channel, input filtered, output ready);

endinterface

// ===== rtl/multichannel_trimmed_mean_decimator.sv =====
// ----------------------------------------------------------------------------
// multichannel_trimmed_mean_decimator
// per-channel olympic filter: every 18 samples of a channel give the mean of
// the 16 middle ones
// ----------------------------------------------------------------------------
// Takes one item per clock. An accepted sample sits in an input register,
// where a single read-modify-write updates its channel's sum, max, min and
// count (all per-channel state is in flip-flops, cleared by reset). On the
// 18th sample of a channel the filtered value goes from the input register
// to an output register, where it is offered until taken. Samples tagged
// with a channel at or above CHANNELS are dropped. While a result waits in
// the output register samples keep flowing; ready drops only once the sample
// in the input register would complete another window, and that sample waits
// there until the pending result is taken.
// ----------------------------------------------------------------------------
module multichannel_trimmed_mean_decimator import tmd_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    tmd_in_if.sink    samples,
    tmd_out_if.source results
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W = 6;

    typedef logic [CH_W-1:0] index_t;

    logic     s1_valid_reg;
    channel_t s1_channel_reg;
    sample_t  s1_sample_reg;

    sum_t    sum_reg   [CHANNELS];
    sample_t max_reg   [CHANNELS];
    sample_t min_reg   [CHANNELS];
    count_t  count_reg [CHANNELS];

    logic     out_valid_reg;
    channel_t out_channel_reg;
    sample_t  filtered_reg;

    logic [CMP_W-1:0] ch_ext;
    logic    in_range;
    index_t  idx;
    sum_t    sum_next;
    sample_t max_next;
    sample_t min_next;
    count_t  count_next;
    cut_t    cut;
    sum_t    trimmed;
    logic    done;
    logic    emits;
    logic    out_free;
    logic    s1_fire;
    logic    in_ready;

    // row update
    always_comb
    begin
        ch_ext     = CMP_W'(s1_channel_reg);
        in_range   = (ch_ext < CMP_W'(CHANNELS));
        idx        = ch_ext[CH_W-1:0];
        sum_next   = sum_reg[idx] + sum_t'(s1_sample_reg);
        max_next   = (s1_sample_reg > max_reg[idx]) ? s1_sample_reg : max_reg[idx];
        min_next   = (s1_sample_reg < min_reg[idx]) ? s1_sample_reg : min_reg[idx];
        count_next = count_reg[idx] + count_t'(1);
        cut        = cut_t'(max_next) + cut_t'(min_next);
        trimmed    = (sum_next >= sum_t'(cut)) ? (sum_next - sum_t'(cut)) : '0;
        done       = (count_next >= WINDOW_LEN);
        emits      = s1_valid_reg && in_range && done;
        out_free   = !out_valid_reg || results.ready;
        s1_fire    = s1_valid_reg && (!emits || out_free);
        in_ready   = !s1_valid_reg || s1_fire;
    end

    assign samples.ready       = in_ready;
    assign results.valid       = out_valid_reg;
    assign results.out_channel = out_channel_reg;
    assign results.filtered    = filtered_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && samples.valid)
        begin
            s1_channel_reg <= samples.channel;
            s1_sample_reg  <= samples.sample;
        end
    end

    // per-channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i]   <= '0;
                max_reg[i]   <= '0;
                min_reg[i]   <= SAMPLE_TOP;
                count_reg[i] <= '0;
            end
        end
        else if (s1_fire && in_range)
        begin
            if (done)
            begin
                sum_reg[idx]   <= '0;
                max_reg[idx]   <= '0;
                min_reg[idx]   <= SAMPLE_TOP;
                count_reg[idx] <= '0;
            end
            else
            begin
                sum_reg[idx]   <= sum_next;
                max_reg[idx]   <= max_next;
                min_reg[idx]   <= min_next;
                count_reg[idx] <= count_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_fire && emits;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_fire && emits)
        begin
            out_channel_reg <= s1_channel_reg;
            filtered_reg    <= trimmed[MEAN_SHIFT +: SAMPLE_W];
        end
    end

endmodule

// ===== rtl/tmd_checker.sv =====
// ----------------------------------------------------------------------------
// tmd_checker
// port-level checks of the trimmed mean decimator, bound to the top level
// ----------------------------------------------------------------------------
module tmd_checker import tmd_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input channel_t out_channel,
    input sample_t  filtered
);

    localparam int CMP_W = 6;

    // result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_channel) && $stable(filtered))
        else $error("result payload changed while stalled");

    // only implemented channels produce results
    a_out_channel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CMP_W'(out_channel) < CMP_W'(CHANNELS)))
        else $error("result for a channel that is not implemented");

    // input side stalls only behind a stalled result
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("sample input stalled without a stalled result");

    // taking a stalled result frees the input unless a new sample is offered
    a_ready_returns: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && out_ready |=> in_ready || in_valid)
        else $error("sample input stayed blocked after the result was taken");

endmodule

bind multichannel_trimmed_mean_decimator tmd_checker #(.CHANNELS(CHANNELS)) u_tmd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (samples.valid),
    .in_ready    (samples.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_channel (results.out_channel),
    .filtered    (results.filtered)
);
